// ----- rtl/gprp_pkg.sv -----
// Package for the gate pattern recorder and player.
// Holds fixed field widths, limits and the result type; no dependencies.
package gprp_pkg;

  // Field and counter widths fixed by the item format
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned SPEED_W  = 3;
  localparam int unsigned ELAP_W   = 19;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned COUNT_W  = 8;

  // Saturation limits and reset values
  localparam logic [DUR_W-1:0]   DUR_MAX        = 16'hFFFF;
  localparam logic [HOLD_W-1:0]  HOLD_MAX       = 16'hFFFF;
  localparam logic [HOLD_W-1:0]  ERASE_HOLD_RST = 16'd3000;

  // Usable speed range
  localparam logic [SPEED_W-1:0] SPEED_MIN = 3'd1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 3'd5;

  // One result item
  typedef struct packed {
    logic               gate;
    logic               recording;
    logic               playing;
    logic [COUNT_W-1:0] stored_count;
  } result_t;

endpackage

// ----- rtl/gprp_in_if.sv -----
// Input channel of the gate pattern recorder: valid/ready plus one tick's payload.
// Depends on gprp_pkg for field widths.
interface gprp_in_if;
  import gprp_pkg::*;

  logic               valid;
  logic               ready;
  logic               pattern_button;
  logic               record_button;
  logic               utility_button;
  logic [SPEED_W-1:0] speed_factor;

  modport source (output valid, output pattern_button, output record_button,
                  output utility_button, output speed_factor, input ready);
  modport sink   (input valid, input pattern_button, input record_button,
                  input utility_button, input speed_factor, output ready);
endinterface

// ----- rtl/gprp_out_if.sv -----
// Result channel of the gate pattern recorder: valid/ready plus one result payload.
// Depends on gprp_pkg for field widths.
interface gprp_out_if;
  import gprp_pkg::*;

  logic               valid;
  logic               ready;
  logic               gate;
  logic               recording;
  logic               playing;
  logic [COUNT_W-1:0] stored_count;

  modport source (output valid, output gate, output recording, output playing,
                  output stored_count, input ready);
  modport sink   (input valid, input gate, input recording, input playing,
                  input stored_count, output ready);
endinterface

// ----- rtl/gprp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gprp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gate_pattern_recorder_player.sv -----
// Gate pattern recorder and player, top level; uses gprp_pkg, gprp_in_if,
// gprp_out_if and gprp_ram. Each input transaction is one millisecond tick and
// yields exactly one result transaction. The block takes one transaction per
// clock cycle while in_ch.ready is high and registers each result; a two-entry
// output stage (output register plus skid register) keeps input accepting while
// a result waits, so in_ch.ready drops only when both entries are full. The
// duration store is a registered-read RAM whose read address follows the next
// play position, so the duration for the coming tick is already in the read
// register when that tick arrives. While record is held, the time between
// pattern button edges is stored (saturating at 65535, up to PATTERN_DEPTH
// entries); afterwards the pattern loops, each duration stretched by the speed
// factor (0 taken as 1, 6 and 7 as 5), with the live pattern button ORed into the
// gate. Holding utility past cfg-set erase_hold_ms ticks during playback erases
// the pattern. stored_count carries the low 8 bits of the stored length.
module gate_pattern_recorder_player #(
  parameter int unsigned PATTERN_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  gprp_in_if.sink                in_ch,
  gprp_out_if.source             out_ch,
  input  logic                   cfg_wr_en,
  input  logic [gprp_pkg::HOLD_W-1:0] cfg_wr_data
);
  import gprp_pkg::*;

  localparam int unsigned AW    = $clog2(PATTERN_DEPTH);
  localparam int unsigned LEN_W = $clog2(PATTERN_DEPTH + 1);
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(PATTERN_DEPTH);

  // Configuration
  logic [HOLD_W-1:0] erase_hold_r;

  // Control state
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [ELAP_W-1:0] elapsed_r, elapsed_nxt;
  logic              gate_lvl_r, gate_lvl_nxt;
  logic              start_lvl_r, start_lvl_nxt;
  logic              last_pat_r, last_pat_nxt;
  logic              rec_act_r, rec_act_nxt;
  logic              play_act_r, play_act_nxt;
  logic              play_started_r, play_started_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;

  // Output stage
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  result_t res;

  // Store access
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [DUR_W-1:0]  st_wdata;
  logic [AW-1:0]     st_raddr;
  logic [DUR_W-1:0]  st_rdata;

  // Datapath helpers
  logic              in_fire;
  logic              pat, rec, util;
  logic [SPEED_W-1:0] speed_eff;
  logic [ELAP_W-1:0] dur_scaled;
  logic [ELAP_W-1:0] elapsed_inc;
  logic [ELAP_W-1:0] rec_elapsed;
  logic [LEN_W-1:0]  pos_inc;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign pat  = in_ch.pattern_button;
  assign rec  = in_ch.record_button;
  assign util = in_ch.utility_button;

  // Clamp speed into its usable range
  always_comb begin
    if (in_ch.speed_factor < SPEED_MIN) begin
      speed_eff = SPEED_MIN;
    end else if (in_ch.speed_factor > SPEED_MAX) begin
      speed_eff = SPEED_MAX;
    end else begin
      speed_eff = in_ch.speed_factor;
    end
  end

  // Stretched duration of the current pattern step
  assign dur_scaled  = ELAP_W'(st_rdata) * ELAP_W'(speed_eff);
  assign elapsed_inc = elapsed_r + ELAP_W'(1);
  assign rec_elapsed = (elapsed_r < ELAP_W'(DUR_MAX)) ? elapsed_inc : elapsed_r;
  assign pos_inc     = LEN_W'(pos_r) + LEN_W'(1);

  // Per-tick next state
  always_comb begin
    len_nxt          = len_r;
    pos_nxt          = pos_r;
    elapsed_nxt      = elapsed_r;
    gate_lvl_nxt     = gate_lvl_r;
    start_lvl_nxt    = start_lvl_r;
    last_pat_nxt     = last_pat_r;
    rec_act_nxt      = rec_act_r;
    play_act_nxt     = play_act_r;
    play_started_nxt = play_started_r;
    hold_nxt         = hold_r;
    st_we            = 1'b0;
    st_waddr         = len_r[AW-1:0];
    st_wdata         = rec_elapsed[DUR_W-1:0];
    res.gate         = pat;

    if (rec_act_r) begin
      // Recording: time each pattern edge
      elapsed_nxt = rec_elapsed;
      if (pat != last_pat_r) begin
        if (len_r < DEPTH_L) begin
          st_we   = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
        elapsed_nxt = '0;
      end
      last_pat_nxt = pat;
      if (!pat && !rec) begin
        rec_act_nxt      = 1'b0;
        play_act_nxt     = (len_nxt != '0);
        play_started_nxt = 1'b0;
        elapsed_nxt      = '0;
        hold_nxt         = '0;
      end
    end else if (rec) begin
      // Start of a new recording
      rec_act_nxt      = 1'b1;
      start_lvl_nxt    = pat;
      last_pat_nxt     = pat;
      elapsed_nxt      = '0;
      len_nxt          = '0;
      pos_nxt          = '0;
      play_act_nxt     = 1'b0;
      play_started_nxt = 1'b0;
      hold_nxt         = '0;
    end else begin
      if (play_act_r) begin
        // Playback step
        if (!play_started_r) begin
          gate_lvl_nxt     = start_lvl_r;
          pos_nxt          = '0;
          elapsed_nxt      = '0;
          play_started_nxt = 1'b1;
        end else if (elapsed_inc >= dur_scaled) begin
          gate_lvl_nxt = !gate_lvl_r;
          elapsed_nxt  = '0;
          pos_nxt      = (pos_inc >= len_r) ? '0 : pos_inc[AW-1:0];
        end else begin
          elapsed_nxt = elapsed_inc;
        end
        // Erase hold counter
        if (util) begin
          if (hold_r >= erase_hold_r) begin
            len_nxt          = '0;
            pos_nxt          = '0;
            play_act_nxt     = 1'b0;
            play_started_nxt = 1'b0;
            elapsed_nxt      = '0;
            gate_lvl_nxt     = 1'b0;
            hold_nxt         = '0;
          end else if (hold_r < HOLD_MAX) begin
            hold_nxt = hold_r + HOLD_W'(1);
          end
        end else begin
          hold_nxt = '0;
        end
      end else begin
        hold_nxt = '0;
      end
      res.gate = play_act_nxt ? (gate_lvl_nxt | pat) : pat;
    end

    res.recording    = rec_act_nxt;
    res.playing      = play_act_nxt;
    res.stored_count = COUNT_W'(len_nxt);
  end

  // Read the duration for the position the next tick will use
  assign st_raddr = in_fire ? pos_nxt : pos_r;

  gprp_ram #(
    .WIDTH (DUR_W),
    .DEPTH (PATTERN_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_hold_r <= ERASE_HOLD_RST;
    end else if (cfg_wr_en) begin
      erase_hold_r <= cfg_wr_data;
    end
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r          <= '0;
      pos_r          <= '0;
      elapsed_r      <= '0;
      gate_lvl_r     <= 1'b1;
      start_lvl_r    <= 1'b0;
      last_pat_r     <= 1'b0;
      rec_act_r      <= 1'b0;
      play_act_r     <= 1'b0;
      play_started_r <= 1'b0;
      hold_r         <= '0;
    end else if (in_fire) begin
      len_r          <= len_nxt;
      pos_r          <= pos_nxt;
      elapsed_r      <= elapsed_nxt;
      gate_lvl_r     <= gate_lvl_nxt;
      start_lvl_r    <= start_lvl_nxt;
      last_pat_r     <= last_pat_nxt;
      rec_act_r      <= rec_act_nxt;
      play_act_r     <= play_act_nxt;
      play_started_r <= play_started_nxt;
      hold_r         <= hold_nxt;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload moves
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (out_ch.ready && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.gate         = out_r.gate;
  assign out_ch.recording    = out_r.recording;
  assign out_ch.playing      = out_r.playing;
  assign out_ch.stored_count = out_r.stored_count;

endmodule

// ----- rtl/gprp_checker.sv -----
// Port-level checks for the gate pattern recorder and player, plus the bind
// that attaches them to the top level. Depends on gprp_pkg for field widths.
module gprp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         gate,
  input logic                         recording,
  input logic                         playing,
  input logic [gprp_pkg::COUNT_W-1:0] stored_count
);
  import gprp_pkg::*;

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(gate) && $stable(recording) &&
      $stable(playing) && $stable(stored_count))
    else $error("result payload changed while stalled");

  // Recording and playback never overlap
  a_modes_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(recording && playing))
    else $error("recording and playing both set");

  // Outside recording and playback the pattern is empty
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !recording && !playing |-> stored_count == '0)
    else $error("pattern not empty while idle");

endmodule

bind gate_pattern_recorder_player gprp_checker u_gprp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .gate         (out_ch.gate),
  .recording    (out_ch.recording),
  .playing      (out_ch.playing),
  .stored_count (out_ch.stored_count)
);

// ----- dv/tb_gate_pattern_recorder_player.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for gate_pattern_recorder_player: per-tick prediction,
// random bursts and stalls on both channels, erase hold time swept between phases.
// Depends on gprp_pkg, gprp_in_if, gprp_out_if and the block's RTL.

module tb_gate_pattern_recorder_player;
  import gprp_pkg::*;

  localparam int unsigned PATTERN_DEPTH = 128;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned LONG_HOLDOFF  = 400;

  // Tracks the recorder/player state tick by tick and holds the results still due
  class gate_scoreboard;
    logic [DUR_W-1:0]   durations [PATTERN_DEPTH];
    logic [COUNT_W-1:0] stored_len;
    logic [COUNT_W-1:0] position;
    logic [ELAP_W-1:0]  elapsed;
    logic               gate_level;
    logic               start_level;
    logic               last_pat;
    logic               rec_on;
    logic               play_on;
    logic               play_begun;
    logic [HOLD_W-1:0]  hold;
    logic [HOLD_W-1:0]  erase_hold;
    result_t            due_results [$];
    int                 errors;

    function new();
      foreach (durations[i]) durations[i] = '0;
      stored_len  = '0;
      position    = '0;
      elapsed     = '0;
      gate_level  = 1'b1;
      start_level = 1'b0;
      last_pat    = 1'b0;
      rec_on      = 1'b0;
      play_on     = 1'b0;
      play_begun  = 1'b0;
      hold        = '0;
      erase_hold  = ERASE_HOLD_RST;
      errors      = 0;
    endfunction

    function void set_erase_hold(logic [HOLD_W-1:0] value);
      erase_hold = value;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // One playback tick; the first one only loads the starting phase
    function void advance_playback(logic [SPEED_W-1:0] spd);
      logic [ELAP_W-1:0] span;
      if (!play_begun) begin
        gate_level = start_level;
        position   = '0;
        elapsed    = '0;
        play_begun = 1'b1;
        return;
      end
      if (position >= stored_len || position >= PATTERN_DEPTH) position = '0;
      span = ELAP_W'(durations[position]) * ELAP_W'(spd);
      elapsed++;
      if (elapsed >= span) begin
        gate_level = ~gate_level;
        elapsed    = '0;
        position++;
        if (position >= stored_len) position = '0;
      end
    endfunction

    // Accepted input transaction: advance the state and queue the expected result
    function void note_tick(logic pat, logic rec, logic util, logic [SPEED_W-1:0] speed);
      logic [SPEED_W-1:0] spd;
      logic               gate;
      result_t            r;
      spd = speed;
      if (spd == '0) spd = SPEED_MIN;
      if (spd > SPEED_MAX) spd = SPEED_MAX;

      if (rec_on) begin
        // measure time between pattern edges, saturating
        if (elapsed < ELAP_W'(DUR_MAX)) elapsed++;
        if (pat != last_pat) begin
          if (stored_len < PATTERN_DEPTH) begin
            durations[stored_len] = elapsed[DUR_W-1:0];
            stored_len++;
          end
          elapsed = '0;
        end
        last_pat = pat;
        gate     = pat;
        if (!pat && !rec) begin
          rec_on     = 1'b0;
          play_on    = (stored_len != '0);
          play_begun = 1'b0;
          elapsed    = '0;
          hold       = '0;
        end
      end else if (rec) begin
        // new take wins over playback and erase
        rec_on      = 1'b1;
        start_level = pat;
        last_pat    = pat;
        elapsed     = '0;
        stored_len  = '0;
        position    = '0;
        play_on     = 1'b0;
        play_begun  = 1'b0;
        hold        = '0;
        gate        = pat;
      end else begin
        if (play_on) begin
          advance_playback(spd);
          if (util) begin
            if (hold >= erase_hold) begin
              stored_len = '0;
              position   = '0;
              play_on    = 1'b0;
              play_begun = 1'b0;
              elapsed    = '0;
              gate_level = 1'b0;
              hold       = '0;
            end else if (hold < HOLD_MAX) begin
              hold++;
            end
          end else begin
            hold = '0;
          end
        end else begin
          hold = '0;
        end
        gate = play_on ? (gate_level | pat) : pat;
      end

      r.gate         = gate;
      r.recording    = rec_on;
      r.playing      = play_on;
      r.stored_count = stored_len;
      due_results.push_back(r);
    endfunction

    function void mismatch(string field, int want, int got);
      errors++;
      $error("%s: expected %0d, actual %0d", field, want, got);
    endfunction

    // Accepted result transaction: compare with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $error("result transaction with no expectation pending");
        return;
      end
      want = due_results.pop_front();
      if (got.gate !== want.gate) mismatch("gate", int'(want.gate), int'(got.gate));
      if (got.recording !== want.recording)
        mismatch("recording", int'(want.recording), int'(got.recording));
      if (got.playing !== want.playing)
        mismatch("playing", int'(want.playing), int'(got.playing));
      if (got.stored_count !== want.stored_count)
        mismatch("stored_count", int'(want.stored_count), int'(got.stored_count));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [HOLD_W-1:0] cfg_wr_data;

  gprp_in_if  in_ch ();
  gprp_out_if out_ch ();

  gate_scoreboard sb = new();

  bit          holdoff_req = 1'b0;
  int          burst_left  = 0;
  int          ticks_sent  = 0;
  int unsigned cycles      = 0;

  gate_pattern_recorder_player #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Random stimulus at the widths of the input fields
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [SPEED_W-1:0] rand_speed();
    return SPEED_W'($urandom_range(0, 7));
  endfunction

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Transaction monitor: inputs are noted before results are checked
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_tick(in_ch.pattern_button, in_ch.record_button, in_ch.utility_button,
                     in_ch.speed_factor);
      if (out_ch.valid && out_ch.ready) begin
        got.gate         = out_ch.gate;
        got.recording    = out_ch.recording;
        got.playing      = out_ch.playing;
        got.stored_count = out_ch.stored_count;
        sb.check_result(got);
      end
    end
  end

  // Receiver: stall pattern changes after runs of random length, one long hold-off on request
  initial begin
    int mode;
    int len;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        if (holdoff_req) begin
          holdoff_req = 1'b0;
          out_ch.ready <= 1'b0;
          repeat (LONG_HOLDOFF) @(posedge clk);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= rand_bit();
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // One tick; the sender sometimes idles between bursts of random length
  task automatic send_tick(input logic pat, input logic rec, input logic util,
                           input logic [SPEED_W-1:0] speed);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.pattern_button <= pat;
    in_ch.record_button  <= rec;
    in_ch.utility_button <= util;
    in_ch.speed_factor   <= speed;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_erase_hold(input logic [HOLD_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_erase_hold(value);
  endtask

  // Well-formed take: start, a number of edges with short random gaps, release
  task automatic record_take(input logic first_level, input int edges, input int max_dur);
    logic level;
    int   dur;
    level = first_level;
    send_tick(level, 1'b1, rand_bit(), rand_speed());
    for (int e = 0; e < edges; e++) begin
      dur = $urandom_range(1, max_dur);
      // record may be let go while the pattern button is still down
      repeat (dur - 1)
        send_tick(level, level ? rand_bit() : 1'b1, rand_bit(), rand_speed());
      level = ~level;
      send_tick(level, 1'b1, rand_bit(), rand_speed());
    end
    send_tick(1'b0, 1'b0, rand_bit(), rand_speed());
  endtask

  // Playback ticks with an occasional live press and a utility hold somewhere inside
  task automatic play_session(input int n, input int hold_len);
    logic [SPEED_W-1:0] spd;
    int                 util_from;
    int                 ticks;
    spd       = rand_speed();
    util_from = $urandom_range(0, n);
    ticks     = (util_from + hold_len + 1 > n) ? util_from + hold_len + 1 : n;
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 7) == 0) spd = rand_speed();
      send_tick($urandom_range(0, 9) == 0, 1'b0,
                (i >= util_from) && (i < util_from + hold_len), spd);
    end
  endtask

  task automatic random_phase(input int n);
    int first;
    int hold_len;
    first = ticks_sent;
    while (ticks_sent - first < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          record_take(rand_bit(), $urandom_range(0, 8), 6);
          hold_len = (sb.erase_hold <= 40) ? $urandom_range(0, sb.erase_hold + 2)
                                            : $urandom_range(0, 6);
          play_session($urandom_range(1, 48), hold_len);
        end
        7, 8: begin
          repeat ($urandom_range(1, 8))
            send_tick(rand_bit(), rand_bit(), rand_bit(), rand_speed());
        end
        default: begin
          // broken take: start, then buttons at random
          send_tick(rand_bit(), 1'b1, rand_bit(), rand_speed());
          repeat ($urandom_range(1, 10))
            send_tick(rand_bit(), rand_bit(), rand_bit(), rand_speed());
        end
      endcase
    end
  endtask

  // Main sequence
  initial begin
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.pattern_button <= 1'b0;
    in_ch.record_button  <= 1'b0;
    in_ch.utility_button <= 1'b0;
    in_ch.speed_factor   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero hold time so the erase shows at once
    write_erase_hold('0);
    send_tick(1'b0, 1'b0, 1'b0, 3'd0);  // idle, speed zero
    send_tick(1'b1, 1'b0, 1'b1, 3'd7);  // idle follows pattern, utility ignored
    send_tick(1'b1, 1'b1, 1'b0, 3'd5);  // take starts high
    send_tick(1'b1, 1'b1, 1'b1, 3'd2);
    send_tick(1'b0, 1'b1, 1'b0, 3'd4);  // edge
    send_tick(1'b1, 1'b1, 1'b0, 3'd6);  // edge after one tick
    send_tick(1'b1, 1'b0, 1'b0, 3'd3);  // record up, pattern down: still recording
    send_tick(1'b0, 1'b0, 1'b0, 3'd1);  // last edge and end of take
    send_tick(1'b0, 1'b0, 1'b0, 3'd0);  // playback loads its phase
    send_tick(1'b0, 1'b0, 1'b0, 3'd7);
    send_tick(1'b1, 1'b0, 1'b0, 3'd6);  // live press ORed in
    send_tick(1'b0, 1'b0, 1'b0, 3'd1);
    send_tick(1'b0, 1'b0, 1'b0, 3'd1);  // steps to the last duration
    send_tick(1'b0, 1'b0, 1'b0, 3'd1);
    send_tick(1'b0, 1'b0, 1'b1, 3'd2);  // erase on first held tick
    send_tick(1'b0, 1'b0, 1'b0, 3'd3);
    send_tick(1'b0, 1'b1, 1'b1, 3'd1);  // take starts low
    send_tick(1'b0, 1'b0, 1'b0, 3'd1);  // empty take: no playback
    send_tick(1'b0, 1'b1, 1'b0, 3'd1);
    send_tick(1'b1, 1'b1, 1'b0, 3'd1);
    send_tick(1'b0, 1'b1, 1'b0, 3'd1);
    send_tick(1'b0, 1'b0, 1'b0, 3'd1);
    send_tick(1'b0, 1'b0, 1'b0, 3'd1);  // playback starts
    send_tick(1'b1, 1'b1, 1'b1, 3'd4);  // record wins over playback and erase
    send_tick(1'b0, 1'b0, 1'b0, 3'd2);

    // Random phases across hold times
    write_erase_hold(HOLD_MAX);
    random_phase(30);
    write_erase_hold(ERASE_HOLD_RST);
    random_phase(30);
    write_erase_hold(HOLD_W'($urandom_range(1, 12)));
    random_phase(30);
    write_erase_hold('0);
    random_phase(30);
    write_erase_hold(HOLD_W'($urandom_range(13, 40)));
    random_phase(30);

    // Full store with extra edges ignored, under a long receiver hold-off
    write_erase_hold(16'd5);
    holdoff_req = 1'b1;
    record_take(1'b0, PATTERN_DEPTH + 8, 2);
    play_session(60, 8);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
